FILE: sv/sla_pkg.sv
// shared types, constants and fixed-point helpers for the advection block
`default_nettype none
package sla_pkg;

  // grid limits
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int IDX_W    = $clog2(MAX_COLS + 1);
  localparam int U_DEPTH  = (MAX_COLS + 1) * MAX_ROWS;
  localparam int V_DEPTH  = MAX_COLS * (MAX_ROWS + 1);
  localparam int S_DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(U_DEPTH > V_DEPTH ? U_DEPTH : V_DEPTH);
  localparam int S_ADDR_W = $clog2(S_DEPTH);

  // datapath widths
  localparam int VAL_W  = 32;
  localparam int OP_W   = 34;
  localparam int WIDE_W = 2 * OP_W;
  localparam int CFG_W  = 31;

  localparam logic [16:0] ONE_Q  = 17'd65536;
  localparam logic [31:0] HALF_Q = 32'd32768;

  localparam logic signed [WIDE_W-1:0] VMAX = {{(WIDE_W-32){1'b0}}, 32'h7fff_ffff};
  localparam logic signed [WIDE_W-1:0] VMIN = {{(WIDE_W-32){1'b1}}, 32'h8000_0000};

  // input function codes
  localparam logic [2:0] FN_LOAD_U  = 3'd0;
  localparam logic [2:0] FN_LOAD_V  = 3'd1;
  localparam logic [2:0] FN_LOAD_S  = 3'd2;
  localparam logic [2:0] FN_QUERY_U = 3'd3;
  localparam logic [2:0] FN_QUERY_V = 3'd4;
  localparam logic [2:0] FN_QUERY_S = 3'd5;

  // grid kinds
  localparam logic [1:0] KIND_U = 2'd0;
  localparam logic [1:0] KIND_V = 2'd1;
  localparam logic [1:0] KIND_S = 2'd2;

  // register indexes
  localparam logic [2:0] REG_DX    = 3'd0;
  localparam logic [2:0] REG_DY    = 3'd1;
  localparam logic [2:0] REG_INVDX = 3'd2;
  localparam logic [2:0] REG_INVDY = 3'd3;
  localparam logic [2:0] REG_DT    = 3'd4;
  localparam logic [2:0] REG_NX    = 3'd5;
  localparam logic [2:0] REG_NY    = 3'd6;

  // trace phases
  localparam logic [2:0] PH_U0 = 3'd0;
  localparam logic [2:0] PH_V0 = 3'd1;
  localparam logic [2:0] PH_UM = 3'd2;
  localparam logic [2:0] PH_VM = 3'd3;
  localparam logic [2:0] PH_FINAL = 3'd4;

  // saturate a wide signed value to a 32-bit word
  function automatic logic signed [VAL_W-1:0] sat(input logic signed [WIDE_W-1:0] v);
    if (v > VMAX) return VMAX[VAL_W-1:0];
    if (v < VMIN) return VMIN[VAL_W-1:0];
    return v[VAL_W-1:0];
  endfunction

  // q16.16 product scaling with floor rounding
  function automatic logic signed [VAL_W-1:0] qm(input logic signed [WIDE_W-1:0] p);
    return sat(p >>> 16);
  endfunction

  // clamp to [0, hi]
  function automatic logic signed [VAL_W-1:0] clamp_rng(input logic signed [VAL_W-1:0] v,
                                                        input logic signed [VAL_W-1:0] hi);
    if (v < 0) return '0;
    if (v > hi) return hi;
    return v;
  endfunction

  // linear address of an element in the store of a kind
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [1:0] kind,
                                                  input logic [IDX_W-1:0] i,
                                                  input logic [IDX_W-1:0] j);
    if (kind == KIND_U) return ADDR_W'(j * (MAX_COLS + 1) + i);
    return ADDR_W'(j * MAX_COLS + i);
  endfunction

endpackage
`default_nettype wire

FILE: sv/sla_ram.sv
// generic single-port-write, registered-read memory
`default_nettype none
module sla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: sv/semi_lagrangian_advection.sv
// semi-lagrangian rk2 advection over u, v and smoke grids held in memories
// loads are written as they are accepted and leave the block idle; a query runs from accept
// to result through five bilinear samples plus five setup and six trace steps, all on one
// shared 34x34 multiplier and one read port
// one item at a time; a load is taken while a result waits, a query's last step holds
// reset returns control to idle and configuration to its defaults; grid stores are undefined until loaded
`default_nettype none
module semi_lagrangian_advection (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // col, row, load_value
  input  wire logic [2:0]  s_axis_tuser,  // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,  // advected_value, out_col, out_row
  output logic      [1:0]  m_axis_tuser,  // grid_kind
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [30:0] cfg_data_i
);

  localparam int IW = sla_pkg::IDX_W;
  localparam int VW = sla_pkg::VAL_W;
  localparam int OW = sla_pkg::OP_W;
  localparam int WW = sla_pkg::WIDE_W;

  typedef enum logic [26:0] {
    S_IDLE = 27'd1 << 0,  S_X0  = 27'd1 << 1,  S_Y0  = 27'd1 << 2,
    S_XL   = 27'd1 << 3,  S_YL  = 27'd1 << 4,  S_YM  = 27'd1 << 5,
    S_SIR  = 27'd1 << 6,  S_SJR = 27'd1 << 7,  S_SJ2 = 27'd1 << 8,
    S_RD0  = 27'd1 << 9,  S_RD1 = 27'd1 << 10, S_RD2 = 27'd1 << 11,
    S_RD3  = 27'd1 << 12, S_M0  = 27'd1 << 13, S_M1  = 27'd1 << 14,
    S_M2   = 27'd1 << 15, S_M3  = 27'd1 << 16, S_M4  = 27'd1 << 17,
    S_M5   = 27'd1 << 18, S_M6  = 27'd1 << 19, S_HX  = 27'd1 << 20,
    S_HY   = 27'd1 << 21, S_HZ  = 27'd1 << 22, S_DX  = 27'd1 << 23,
    S_DY   = 27'd1 << 24, S_DZ  = 27'd1 << 25, S_PAD = 27'd1 << 26
  } state_e;

  // configuration
  logic [30:0] dx_q, dy_q, inv_dx_q, inv_dy_q, dt_q;
  logic [6:0]  nx_cfg_q, ny_cfg_q;

  // control and datapath registers
  state_e state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic [1:0] kind_q, kind_d, sk_q, sk_d;
  logic [IW-1:0] col_q, col_d, row_q, row_d, i_q, i_d, j_q, j_d;
  logic signed [VW-1:0] x0_q, x0_d, y0_q, y0_d, xmax_q, xmax_d, ymax_q, ymax_d;
  logic signed [VW-1:0] xs_q, xs_d, ys_q, ys_d, ir_q, ir_d, jr_q, jr_d;
  logic signed [VW-1:0] c00_q, c00_d, c10_q, c10_d, c01_q, c01_d, c11_q, c11_d;
  logic signed [VW-1:0] t_q, t_d, acc_a_q, acc_a_d, acc_b_q, acc_b_d;
  logic signed [VW-1:0] vel_u_q, vel_u_d, vel_v_q, vel_v_d;
  logic signed [WW-1:0] prod_q;
  logic signed [OW-1:0] mul_a, mul_b;
  logic out_valid_q, out_valid_d;
  logic [VW-1:0] out_val_q, out_val_d;
  logic [IW-1:0] out_col_q, out_col_d, out_row_q, out_row_d;
  logic [1:0] out_kind_q, out_kind_d;

  // input beat fields
  logic [2:0]    in_func;
  logic [IW-1:0] in_col, in_row;
  logic [VW-1:0] in_val;
  logic [1:0]    in_kind;
  logic          in_fire, in_ok;
  assign in_func = s_axis_tuser;
  assign in_col  = s_axis_tdata[6:0];
  assign in_row  = s_axis_tdata[13:7];
  assign in_val  = s_axis_tdata[45:14];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // effective grid size
  logic [IW-1:0] nx_eff, ny_eff;
  assign nx_eff = (nx_cfg_q < 7'd2) ? IW'(2) :
                  (nx_cfg_q > 7'(sla_pkg::MAX_COLS)) ? IW'(sla_pkg::MAX_COLS) : nx_cfg_q;
  assign ny_eff = (ny_cfg_q < 7'd2) ? IW'(2) :
                  (ny_cfg_q > 7'(sla_pkg::MAX_ROWS)) ? IW'(sla_pkg::MAX_ROWS) : ny_cfg_q;

  // input decode
  always_comb begin
    case (in_func)
      sla_pkg::FN_LOAD_U, sla_pkg::FN_QUERY_U: in_kind = sla_pkg::KIND_U;
      sla_pkg::FN_LOAD_V, sla_pkg::FN_QUERY_V: in_kind = sla_pkg::KIND_V;
      default:                                 in_kind = sla_pkg::KIND_S;
    endcase
  end
  assign in_ok = (in_func <= sla_pkg::FN_QUERY_S) &&
                 (in_col < nx_eff + IW'(in_kind == sla_pkg::KIND_U)) &&
                 (in_row < ny_eff + IW'(in_kind == sla_pkg::KIND_V));

  // memory write side
  logic load_fire;
  logic [sla_pkg::ADDR_W-1:0] waddr;
  assign load_fire = in_fire && in_ok && (in_func < sla_pkg::FN_QUERY_U);
  assign waddr = sla_pkg::elem_addr(in_kind, in_col, in_row);

  // corner index clamp of the current sample
  logic [IW-1:0] wmax, hmax, ci_clamp, cj_clamp;
  logic signed [15:0] ii, jj;
  assign wmax = nx_eff + IW'(sk_q == sla_pkg::KIND_U) - IW'(2);
  assign hmax = ny_eff + IW'(sk_q == sla_pkg::KIND_V) - IW'(2);
  assign ii = ir_q[31:16];
  assign jj = jr_q[31:16];
  always_comb begin
    if (ii[15]) ci_clamp = '0;
    else if (ii[14:0] > 15'(wmax)) ci_clamp = wmax;
    else ci_clamp = ii[IW-1:0];
    if (jj[15]) cj_clamp = '0;
    else if (jj[14:0] > 15'(hmax)) cj_clamp = hmax;
    else cj_clamp = jj[IW-1:0];
  end

  // memory read side
  logic [IW-1:0] rd_i, rd_j;
  logic [sla_pkg::ADDR_W-1:0] raddr;
  always_comb begin
    case (state_q)
      S_RD0:   begin rd_i = ci_clamp;     rd_j = cj_clamp;     end
      S_RD1:   begin rd_i = i_q + IW'(1); rd_j = j_q;          end
      S_RD2:   begin rd_i = i_q;          rd_j = j_q + IW'(1); end
      default: begin rd_i = i_q + IW'(1); rd_j = j_q + IW'(1); end
    endcase
  end
  assign raddr = sla_pkg::elem_addr(sk_q, rd_i, rd_j);

  logic [VW-1:0] u_rdata, v_rdata, s_rdata;
  logic signed [VW-1:0] rdata;
  assign rdata = (sk_q == sla_pkg::KIND_U) ? u_rdata :
                 (sk_q == sla_pkg::KIND_V) ? v_rdata : s_rdata;

  sla_ram #(.WIDTH(VW), .DEPTH(sla_pkg::U_DEPTH)) u_store (
    .clk_i, .we_i(load_fire && in_kind == sla_pkg::KIND_U),
    .waddr_i(waddr), .wdata_i(in_val), .raddr_i(raddr), .rdata_o(u_rdata)
  );
  sla_ram #(.WIDTH(VW), .DEPTH(sla_pkg::V_DEPTH)) v_store (
    .clk_i, .we_i(load_fire && in_kind == sla_pkg::KIND_V),
    .waddr_i(waddr), .wdata_i(in_val), .raddr_i(raddr), .rdata_o(v_rdata)
  );
  sla_ram #(.WIDTH(VW), .DEPTH(sla_pkg::S_DEPTH)) s_store (
    .clk_i, .we_i(load_fire && in_kind == sla_pkg::KIND_S),
    .waddr_i(waddr[sla_pkg::S_ADDR_W-1:0]), .wdata_i(in_val),
    .raddr_i(raddr[sla_pkg::S_ADDR_W-1:0]), .rdata_o(s_rdata)
  );

  // fractions and scaled product
  logic [15:0] fx, fy;
  logic signed [VW-1:0] qprod, res, half_x, half_y;
  assign fx = ir_q[15:0];
  assign fy = jr_q[15:0];
  assign qprod = sla_pkg::qm(prod_q);
  assign res = sla_pkg::sat(WW'(t_q) + WW'(qprod));
  assign half_x = (sk_q == sla_pkg::KIND_U) ? '0 : sla_pkg::HALF_Q;
  assign half_y = (sk_q == sla_pkg::KIND_V) ? '0 : sla_pkg::HALF_Q;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_X0: begin
        mul_a = (kind_q == sla_pkg::KIND_U) ? OW'(col_q) : OW'({col_q, 1'b1});
        mul_b = OW'(dx_q);
      end
      S_Y0: begin
        mul_a = (kind_q == sla_pkg::KIND_V) ? OW'(row_q) : OW'({row_q, 1'b1});
        mul_b = OW'(dy_q);
      end
      S_XL:  begin mul_a = OW'(nx_eff - IW'(1)); mul_b = OW'(dx_q); end
      S_YL:  begin mul_a = OW'(ny_eff - IW'(1)); mul_b = OW'(dy_q); end
      S_SIR: begin mul_a = OW'(xs_q); mul_b = OW'(inv_dx_q); end
      S_SJR: begin mul_a = OW'(ys_q); mul_b = OW'(inv_dy_q); end
      S_M0:  begin mul_a = OW'(sla_pkg::ONE_Q - 17'(fx)); mul_b = OW'(c00_q); end
      S_M1:  begin mul_a = OW'(fx); mul_b = OW'(c10_q); end
      S_M2:  begin mul_a = OW'(sla_pkg::ONE_Q - 17'(fx)); mul_b = OW'(c01_q); end
      S_M3:  begin mul_a = OW'(fx); mul_b = OW'(c11_q); end
      S_M4:  begin mul_a = OW'(sla_pkg::ONE_Q - 17'(fy)); mul_b = OW'(acc_a_q); end
      S_M5, S_M6: begin mul_a = OW'(fy); mul_b = OW'(acc_b_q); end
      S_HX, S_DX: begin mul_a = OW'(dt_q); mul_b = OW'(vel_u_q); end
      S_HY, S_DY: begin mul_a = OW'(dt_q); mul_b = OW'(vel_v_q); end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;     phase_d = phase_q;   kind_d = kind_q;   sk_d = sk_q;
    col_d = col_q;         row_d = row_q;       i_d = i_q;         j_d = j_q;
    x0_d = x0_q;           y0_d = y0_q;         xmax_d = xmax_q;   ymax_d = ymax_q;
    xs_d = xs_q;           ys_d = ys_q;         ir_d = ir_q;       jr_d = jr_q;
    c00_d = c00_q;         c10_d = c10_q;       c01_d = c01_q;     c11_d = c11_q;
    t_d = t_q;             acc_a_d = acc_a_q;   acc_b_d = acc_b_q;
    vel_u_d = vel_u_q;     vel_v_d = vel_v_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_val_d = out_val_q; out_col_d = out_col_q; out_row_d = out_row_q;
    out_kind_d = out_kind_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && in_ok && in_func >= sla_pkg::FN_QUERY_U) begin
          kind_d  = in_kind;
          col_d   = in_col;
          row_d   = in_row;
          state_d = S_X0;
        end
      end
      S_X0: state_d = S_Y0;
      S_Y0: begin
        x0_d = (kind_q == sla_pkg::KIND_U) ? sla_pkg::sat(prod_q) : sla_pkg::sat(prod_q >>> 1);
        state_d = S_XL;
      end
      S_XL: begin
        y0_d = (kind_q == sla_pkg::KIND_V) ? sla_pkg::sat(prod_q) : sla_pkg::sat(prod_q >>> 1);
        state_d = S_YL;
      end
      S_YL: begin
        xmax_d  = sla_pkg::sat(prod_q);
        state_d = S_YM;
      end
      S_YM: begin
        ymax_d  = sla_pkg::sat(prod_q);
        xs_d    = x0_q;
        ys_d    = y0_q;
        sk_d    = sla_pkg::KIND_U;
        phase_d = sla_pkg::PH_U0;
        state_d = S_SIR;
      end
      S_SIR: state_d = S_SJR;
      S_SJR: begin
        ir_d    = sla_pkg::sat(WW'(qprod) - WW'(half_x));
        state_d = S_SJ2;
      end
      S_SJ2: begin
        jr_d    = sla_pkg::sat(WW'(qprod) - WW'(half_y));
        state_d = S_RD0;
      end
      S_RD0: begin
        i_d = ci_clamp;
        j_d = cj_clamp;
        state_d = S_RD1;
      end
      S_RD1: begin c00_d = rdata; state_d = S_RD2; end
      S_RD2: begin c10_d = rdata; state_d = S_RD3; end
      S_RD3: begin c01_d = rdata; state_d = S_M0; end
      S_M0:  begin c11_d = rdata; state_d = S_M1; end
      S_M1:  begin t_d = qprod; state_d = S_M2; end
      S_M2:  begin acc_a_d = res; state_d = S_M3; end
      S_M3:  begin t_d = qprod; state_d = S_M4; end
      S_M4:  begin acc_b_d = res; state_d = S_M5; end
      S_M5:  begin t_d = qprod; state_d = S_M6; end
      S_M6: begin
        case (phase_q)
          sla_pkg::PH_U0: begin
            vel_u_d = res; sk_d = sla_pkg::KIND_V; phase_d = sla_pkg::PH_V0; state_d = S_SIR;
          end
          sla_pkg::PH_V0: begin
            vel_v_d = res; state_d = S_HX;
          end
          sla_pkg::PH_UM: begin
            vel_u_d = res; sk_d = sla_pkg::KIND_V; phase_d = sla_pkg::PH_VM; state_d = S_SIR;
          end
          sla_pkg::PH_VM: begin
            vel_v_d = res; state_d = S_DX;
          end
          default: begin
            // final sample waits for the output register to free up
            if (!out_valid_q || m_axis_tready) begin
              out_valid_d = 1'b1;
              out_val_d   = res;
              out_col_d   = col_q;
              out_row_d   = row_q;
              out_kind_d  = kind_q;
              state_d     = S_IDLE;
            end
          end
        endcase
      end
      S_HX: state_d = S_HY;
      S_HY: begin
        xs_d    = sla_pkg::sat(WW'(x0_q) - (prod_q >>> 17));
        state_d = S_HZ;
      end
      S_HZ: begin
        ys_d    = sla_pkg::sat(WW'(y0_q) - (prod_q >>> 17));
        sk_d    = sla_pkg::KIND_U;
        phase_d = sla_pkg::PH_UM;
        state_d = S_SIR;
      end
      S_DX: state_d = S_DY;
      S_DY: begin
        xs_d    = sla_pkg::clamp_rng(sla_pkg::sat(WW'(x0_q) - WW'(qprod)), xmax_q);
        state_d = S_DZ;
      end
      S_DZ: begin
        ys_d    = sla_pkg::clamp_rng(sla_pkg::sat(WW'(y0_q) - WW'(qprod)), ymax_q);
        sk_d    = kind_q;
        phase_d = sla_pkg::PH_FINAL;
        state_d = S_SIR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dx_q        <= 31'd65536;
      dy_q        <= 31'd65536;
      inv_dx_q    <= 31'd65536;
      inv_dy_q    <= 31'd65536;
      dt_q        <= 31'd655;
      nx_cfg_q    <= 7'd64;
      ny_cfg_q    <= 7'd64;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          sla_pkg::REG_DX:    dx_q     <= cfg_data_i;
          sla_pkg::REG_DY:    dy_q     <= cfg_data_i;
          sla_pkg::REG_INVDX: inv_dx_q <= cfg_data_i;
          sla_pkg::REG_INVDY: inv_dy_q <= cfg_data_i;
          sla_pkg::REG_DT:    dt_q     <= cfg_data_i;
          sla_pkg::REG_NX:    nx_cfg_q <= cfg_data_i[6:0];
          sla_pkg::REG_NY:    ny_cfg_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    phase_q <= phase_d;   kind_q <= kind_d;     sk_q <= sk_d;
    col_q   <= col_d;     row_q <= row_d;       i_q <= i_d;       j_q <= j_d;
    x0_q    <= x0_d;      y0_q <= y0_d;         xmax_q <= xmax_d; ymax_q <= ymax_d;
    xs_q    <= xs_d;      ys_q <= ys_d;         ir_q <= ir_d;     jr_q <= jr_d;
    c00_q   <= c00_d;     c10_q <= c10_d;       c01_q <= c01_d;   c11_q <= c11_d;
    t_q     <= t_d;       acc_a_q <= acc_a_d;   acc_b_q <= acc_b_d;
    vel_u_q <= vel_u_d;   vel_v_q <= vel_v_d;
    out_val_q <= out_val_d; out_col_q <= out_col_d; out_row_q <= out_row_d;
    out_kind_q <= out_kind_d;
  end

  // output beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_row_q, out_col_q, out_val_q};
  assign m_axis_tuser  = out_kind_q;

  // checks
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_result_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_M6 && phase_q == sla_pkg::PH_FINAL))
    else $error("result raised outside the final sample");

  a_corner_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD1 |-> (i_q <= wmax && j_q <= hmax))
    else $error("corner index beyond grid");

endmodule
`default_nettype wire
